FILE: hw/rtl/rjpu_pkg.sv
package rjpu_pkg;

	localparam int CFG_COUNT = 8;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_A  = 3'd0,
		REG_ROW0_B  = 3'd1,
		REG_ROW1_A  = 3'd2,
		REG_ROW1_B  = 3'd3,
		REG_ROW2_A  = 3'd4,
		REG_ROW2_B  = 3'd5,
		REG_AXIS_XY = 3'd6,
		REG_AXIS_ZO = 3'd7
	} cfg_reg_t;

	localparam logic [63:0] CFG_RESET [CFG_COUNT] = '{
		64'd65536, 64'd0, 64'd281474976710656, 64'd0,
		64'd0, 64'd65536, 64'd0, 64'd65536
	};

	localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
	localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
	localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;
	localparam int ATAN_COUNT = 24;

	localparam logic [31:0] ATAN_Q30 [ATAN_COUNT] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	typedef struct packed {
		logic signed [15:0] joint_angle;
		logic signed [31:0] parent_c0;
		logic signed [31:0] parent_c1;
		logic signed [31:0] parent_c2;
		logic signed [31:0] parent_c3;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pose_c0;
		logic signed [31:0] pose_c1;
		logic signed [31:0] pose_c2;
		logic signed [31:0] pose_c3;
	} out_item_t;

endpackage

FILE: hw/rtl/rjpu_cordic.sv
module rjpu_cordic import rjpu_pkg::*; #(
	parameter int STAGES = 16,
	parameter int TAG_W = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [15:0]      angle,
	input  logic [TAG_W-1:0]        in_tag,
	output logic                    out_valid,
	output logic signed [63:0]      cos_q30,
	output logic signed [63:0]      sin_q30,
	output logic                    out_neg,
	output logic [TAG_W-1:0]        out_tag
);

	logic                    v_s   [STAGES+1];
	logic signed [63:0]      x_s   [STAGES+1];
	logic signed [63:0]      y_s   [STAGES+1];
	logic signed [63:0]      z_s   [STAGES+1];
	logic                    neg_s [STAGES+1];
	logic [TAG_W-1:0]        tag_s [STAGES+1];
	logic signed [63:0]      z_in;

	// Range reduction: angles beyond a quarter turn are folded by pi.
	always_comb begin
		z_in = 64'(angle) * 64'sd131072;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= GAIN_Q30;
		y_s[0]   <= '0;
		tag_s[0] <= in_tag;
		if (z_in > HALF_PI_Q30) begin
			z_s[0] <= z_in - PI_Q30;
			neg_s[0] <= 1'b1;
		end else if (z_in < -HALF_PI_Q30) begin
			z_s[0] <= z_in + PI_Q30;
			neg_s[0] <= 1'b1;
		end else begin
			z_s[0] <= z_in;
			neg_s[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [63:0] xs, ys, at;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign at = (i < ATAN_COUNT) ? 64'(signed'({1'b0, ATAN_Q30[i]})) : 64'sd0;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			tag_s[i+1] <= tag_s[i];
			if (i >= ATAN_COUNT) begin
				x_s[i+1] <= x_s[i];
				y_s[i+1] <= y_s[i];
				z_s[i+1] <= z_s[i];
			end else if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - at;
			end else begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + at;
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign cos_q30   = x_s[STAGES];
	assign sin_q30   = y_s[STAGES];
	assign out_neg   = neg_s[STAGES];
	assign out_tag   = tag_s[STAGES];

endmodule

FILE: hw/rtl/revolute_joint_pose_update_top.sv
// Pose row update for a revolute joint: one parent pose row goes in per cycle
// when start is high and busy is low, and one global pose row comes out on
// done after the CORDIC stage chain and the Rodrigues, local-transform and
// parent-row multiply stages. busy is never raised, since the pipeline
// accepts a row every cycle and the receiver must take each result in the
// cycle that done is high.
// Configuration registers may only be written while no row is in flight.
module revolute_joint_pose_update_top import rjpu_pkg::*; #(
	parameter int ENTRY_WIDTH = 32,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             in_item,
	output logic                 done,
	output out_item_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int EW = ENTRY_WIDTH;
	localparam int PW = 4 * 32;

	typedef logic signed [EW-1:0] ent_t;

	function automatic ent_t fmul(input ent_t a, input ent_t b);
		logic signed [2*EW-1:0] p;
		begin
			p = (2*EW)'(a) * (2*EW)'(b);
			fmul = ent_t'(p >>> 16);
		end
	endfunction

	logic [63:0] cfg_q [CFG_COUNT];

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++) cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_valid) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	ent_t lm [3][4];
	ent_t k [3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			lm[r][0] = ent_t'(cfg_q[2*r][31:0]);
			lm[r][1] = ent_t'(cfg_q[2*r][63:32]);
			lm[r][2] = ent_t'(cfg_q[2*r+1][31:0]);
			lm[r][3] = ent_t'(cfg_q[2*r+1][63:32]);
		end
		k[0] = ent_t'(cfg_q[REG_AXIS_XY][31:0]);
		k[1] = ent_t'(cfg_q[REG_AXIS_XY][63:32]);
		k[2] = ent_t'(cfg_q[REG_AXIS_ZO][31:0]);
	end

	logic signed [15:0] angle;
	assign angle = in_item.joint_angle + cfg_q[REG_AXIS_ZO][47:32];

	logic                 cv;
	logic signed [63:0]   cx, cy;
	logic                 cneg;
	logic [PW-1:0]        ctag;

	rjpu_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(PW)) u_cordic (
		.clk(clk), .arst_n(arst_n),
		.in_valid(start), .angle(angle),
		.in_tag({in_item.parent_c0, in_item.parent_c1,
			in_item.parent_c2, in_item.parent_c3}),
		.out_valid(cv), .cos_q30(cx), .sin_q30(cy), .out_neg(cneg), .out_tag(ctag)
	);

	// Stage 1: cos, sin and 1 - cos in entry format.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	ent_t c_s1, s_s1, t_s1;
	logic [PW-1:0] p_s1, p_s2, p_s3, p_s4, p_s5, p_s6;
	ent_t cc, ss;
	always_comb begin
		cc = ent_t'(cx >>> 14);
		ss = ent_t'(cy >>> 14);
		if (cneg) begin
			cc = -cc;
			ss = -ss;
		end
	end
	always_ff @(posedge clk) begin
		c_s1 <= cc;
		s_s1 <= ss;
		t_s1 <= ent_t'(32'sd65536) - cc;
		p_s1 <= ctag;
	end

	// Stage 2: t*k and s*k.
	ent_t c_s2, tk_s2 [3], sk_s2 [3];
	always_ff @(posedge clk) begin
		c_s2 <= c_s1;
		p_s2 <= p_s1;
		for (int i = 0; i < 3; i++) begin
			tk_s2[i] <= fmul(t_s1, k[i]);
			sk_s2[i] <= fmul(s_s1, k[i]);
		end
	end

	// Stage 3: (t*ki)*kj terms.
	ent_t c_s3, sk_s3 [3], tkk_s3 [3][3];
	always_ff @(posedge clk) begin
		c_s3 <= c_s2;
		p_s3 <= p_s2;
		for (int i = 0; i < 3; i++) begin
			sk_s3[i] <= sk_s2[i];
			for (int j = 0; j < 3; j++) tkk_s3[i][j] <= fmul(tk_s2[i], k[j]);
		end
	end

	// Stage 4: rotation matrix.
	ent_t rm_s4 [3][3];
	always_ff @(posedge clk) begin
		p_s4 <= p_s3;
		rm_s4[0][0] <= tkk_s3[0][0] + c_s3;
		rm_s4[1][1] <= tkk_s3[1][1] + c_s3;
		rm_s4[2][2] <= tkk_s3[2][2] + c_s3;
		rm_s4[0][1] <= tkk_s3[0][1] - sk_s3[2];
		rm_s4[0][2] <= tkk_s3[0][2] + sk_s3[1];
		rm_s4[1][0] <= tkk_s3[1][0] + sk_s3[2];
		rm_s4[1][2] <= tkk_s3[1][2] - sk_s3[0];
		rm_s4[2][0] <= tkk_s3[2][0] - sk_s3[1];
		rm_s4[2][1] <= tkk_s3[2][1] + sk_s3[0];
	end

	// Stage 5: products of L and R; stage 6: sums into M.
	ent_t lr_s5 [3][3][3];
	ent_t m_s6 [3][3];
	always_ff @(posedge clk) begin
		p_s5 <= p_s4;
		p_s6 <= p_s5;
		for (int r = 0; r < 3; r++)
			for (int j = 0; j < 3; j++) begin
				for (int q = 0; q < 3; q++) lr_s5[r][j][q] <= fmul(lm[r][q], rm_s4[q][j]);
				m_s6[r][j] <= lr_s5[r][j][0] + lr_s5[r][j][1] + lr_s5[r][j][2];
			end
	end

	ent_t pp [4];
	always_comb begin
		pp[0] = ent_t'(p_s6[127:96]);
		pp[1] = ent_t'(p_s6[95:64]);
		pp[2] = ent_t'(p_s6[63:32]);
		pp[3] = ent_t'(p_s6[31:0]);
	end

	// Stage 7: parent row products; stage 8: sums.
	ent_t pm_s7 [4][3];
	ent_t p3_s7;
	ent_t o_s8 [4];
	always_ff @(posedge clk) begin
		p3_s7 <= pp[3];
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) pm_s7[j][r] <= fmul(pp[r], m_s6[r][j]);
			pm_s7[3][r] <= fmul(pp[r], lm[r][3]);
		end
		for (int j = 0; j < 3; j++) o_s8[j] <= pm_s7[j][0] + pm_s7[j][1] + pm_s7[j][2];
		o_s8[3] <= pm_s7[3][0] + pm_s7[3][1] + pm_s7[3][2] + p3_s7;
	end

	out_item_t res_s9;
	always_ff @(posedge clk) begin
		res_s9.pose_c0 <= 32'(o_s8[0]);
		res_s9.pose_c1 <= 32'(o_s8[1]);
		res_s9.pose_c2 <= 32'(o_s8[2]);
		res_s9.pose_c3 <= 32'(o_s8[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <=
				{cv, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	assign done = v_s9;
	assign result = res_s9;

endmodule

FILE: hw/rtl/rjpu_checker.sv
module rjpu_checker import rjpu_pkg::*; #(
	parameter int LATENCY = 26
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic done,
	input  logic cfg_valid,
	input  logic cfg_ready
);

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching transfer");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind revolute_joint_pose_update_top rjpu_checker #(.LATENCY(CORDIC_STAGES + 10)) u_rjpu_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

FILE: test/tb_revolute_joint_pose_update_top.sv
`timescale 1ns / 1ps

module tb_revolute_joint_pose_update_top;
	import rjpu_pkg::*;

	localparam int ENTRY_WIDTH   = 32;
	localparam int CORDIC_STAGES = 16;
	localparam int PIPE_LATENCY  = CORDIC_STAGES + 10;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	in_item_t             in_item = '0;
	logic                 done;
	out_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;

	logic [63:0] cfg_shadow [CFG_COUNT];
	in_item_t    row_q [$];
	out_item_t   pose_q [$];
	int          gap_left = 0;
	bit          no_idle = 1'b0;
	int          mismatches = 0;
	int          orphans = 0;

	revolute_joint_pose_update_top #(
		.ENTRY_WIDTH(ENTRY_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint wrap_entry(longint v);
		return longint'(int'(v));
	endfunction

	function automatic longint qmul(longint a, longint b);
		return wrap_entry((a * b) >>> 16);
	endfunction

	function automatic longint reg_half(logic [63:0] r, bit hi);
		return hi ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
	endfunction

	// Parent row times (L * R) with a CORDIC rotation about the configured axis.
	function automatic out_item_t pose_predict(in_item_t it);
		logic signed [15:0] ang;
		longint z, x, y, xs, ys, c, s, t, acc;
		longint k [3];
		longint rot [3][3];
		longint loc [3][4];
		longint m [3][4];
		longint p [4];
		longint row [4];
		bit flip;
		out_item_t o;
		ang = it.joint_angle + signed'(cfg_shadow[REG_AXIS_ZO][47:32]);
		z = longint'(ang) * 131072;
		flip = 1'b0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1'b1;
		end
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < ATAN_COUNT; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
			end
		end
		c = wrap_entry(x >>> 14);
		s = wrap_entry(y >>> 14);
		if (flip) begin
			c = wrap_entry(-c);
			s = wrap_entry(-s);
		end
		k[0] = reg_half(cfg_shadow[REG_AXIS_XY], 1'b0);
		k[1] = reg_half(cfg_shadow[REG_AXIS_XY], 1'b1);
		k[2] = reg_half(cfg_shadow[REG_AXIS_ZO], 1'b0);
		t = wrap_entry(65536 - c);
		for (int r = 0; r < 3; r++)
			for (int j = 0; j < 3; j++)
				rot[r][j] = qmul(qmul(t, k[r]), k[j]);
		for (int d = 0; d < 3; d++)
			rot[d][d] = wrap_entry(rot[d][d] + c);
		rot[0][1] = wrap_entry(rot[0][1] - qmul(s, k[2]));
		rot[0][2] = wrap_entry(rot[0][2] + qmul(s, k[1]));
		rot[1][0] = wrap_entry(rot[1][0] + qmul(s, k[2]));
		rot[1][2] = wrap_entry(rot[1][2] - qmul(s, k[0]));
		rot[2][0] = wrap_entry(rot[2][0] - qmul(s, k[1]));
		rot[2][1] = wrap_entry(rot[2][1] + qmul(s, k[0]));
		for (int r = 0; r < 3; r++) begin
			loc[r][0] = reg_half(cfg_shadow[2 * r], 1'b0);
			loc[r][1] = reg_half(cfg_shadow[2 * r], 1'b1);
			loc[r][2] = reg_half(cfg_shadow[2 * r + 1], 1'b0);
			loc[r][3] = reg_half(cfg_shadow[2 * r + 1], 1'b1);
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int q = 0; q < 3; q++)
					acc = wrap_entry(acc + qmul(loc[r][q], rot[q][j]));
				m[r][j] = acc;
			end
			m[r][3] = loc[r][3];
		end
		p[0] = it.parent_c0;
		p[1] = it.parent_c1;
		p[2] = it.parent_c2;
		p[3] = it.parent_c3;
		for (int j = 0; j < 4; j++) begin
			acc = 0;
			for (int r = 0; r < 3; r++)
				acc = wrap_entry(acc + qmul(p[r], m[r][j]));
			if (j == 3)
				acc = wrap_entry(acc + p[3]);
			row[j] = acc;
		end
		o.pose_c0 = row[0][31:0];
		o.pose_c1 = row[1][31:0];
		o.pose_c2 = row[2][31:0];
		o.pose_c3 = row[3][31:0];
		return o;
	endfunction

	// Driver: a row is taken on every edge with start high and busy low.
	always @(posedge clk) begin
		bit taken;
		int gap_now;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			taken = start && !busy;
			gap_now = gap_left;
			if (taken) begin
				pose_q.push_back(pose_predict(in_item));
				void'(row_q.pop_front());
				gap_now = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (gap_now == 0 && row_q.size() > 0) begin
				start <= 1'b1;
				in_item <= row_q[0];
				gap_left <= 0;
			end else begin
				start <= 1'b0;
				gap_left <= (gap_now > 0) ? gap_now - 1 : 0;
			end
		end
	end

	// Monitor: every done pulse is a transfer that cannot be held off.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (pose_q.size() == 0) begin
				orphans++;
				$display("Unexpected pose row %h", result);
			end else begin
				want = pose_q.pop_front();
				if (want.pose_c0 !== result.pose_c0 || want.pose_c1 !== result.pose_c1 ||
						want.pose_c2 !== result.pose_c2 || want.pose_c3 !== result.pose_c3) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Pose mismatch: expected %h %h %h %h, got %h %h %h %h",
							want.pose_c0, want.pose_c1, want.pose_c2, want.pose_c3,
							result.pose_c0, result.pose_c1, result.pose_c2, result.pose_c3);
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_shadow[idx] = val;
	endtask

	task automatic drain();
		while (row_q.size() > 0 || start || pose_q.size() > 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 10) @(posedge clk);
	endtask

	task automatic push_row(logic [15:0] a, logic [31:0] p0, logic [31:0] p1,
			logic [31:0] p2, logic [31:0] p3);
		in_item_t it;
		it.joint_angle = a;
		it.parent_c0 = p0;
		it.parent_c1 = p1;
		it.parent_c2 = p2;
		it.parent_c3 = p3;
		row_q.push_back(it);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] rand_entry();
		// Mostly modest values so results stay meaningful; some full-range words.
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'(int'($urandom_range(0, 524288)) - 262144);
	endfunction

	function automatic logic [31:0] unit_comp();
		case ($urandom_range(0, 4))
			0: return 32'd65536;
			1: return -32'sd65536;
			2: return 32'd46341;
			3: return -32'sd46341;
			default: return 32'd0;
		endcase
	endfunction

	initial begin
		logic [15:0] angles [12];
		angles = '{16'h0000, 16'h7FFF, 16'h8000, 16'd12868, 16'd12869, -16'sd12868,
			-16'sd12869, 16'd25736, -16'sd25736, 16'd1, 16'hFFFF, 16'd6434};
		for (int i = 0; i < CFG_COUNT; i++)
			cfg_shadow[i] = CFG_RESET[i];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: identity local transform, rotation about z.
		foreach (angles[i])
			push_row(angles[i], 32'd65536, 32'd0, 32'd0, 32'd131072);
		push_row(16'd6434, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		push_row(16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF);
		push_row(16'h7FFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001, 32'h00000000);
		push_row(16'd3000, 32'd0, 32'd65536, 32'd65536, 32'hFFFF0000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 6; r++) begin
				case (ph)
					0: write_reg(cfg_reg_t'(r), 64'h0);
					1: write_reg(cfg_reg_t'(r), 64'hFFFF_FFFF_FFFF_FFFF);
					2: write_reg(cfg_reg_t'(r), {32'h7FFFFFFF, 32'h80000000});
					default: write_reg(cfg_reg_t'(r), {rand_entry(), rand_entry()});
				endcase
			end
			case (ph)
				0: begin
					write_reg(REG_AXIS_XY, 64'h0);
					write_reg(REG_AXIS_ZO, 64'h0);
				end
				1: begin
					write_reg(REG_AXIS_XY, 64'hFFFF_FFFF_FFFF_FFFF);
					write_reg(REG_AXIS_ZO, 64'hFFFF_FFFF_FFFF_FFFF);
				end
				2: begin
					// Not a unit axis: it must be used exactly as written.
					write_reg(REG_AXIS_XY, {32'h80000000, 32'h7FFFFFFF});
					write_reg(REG_AXIS_ZO, {16'hA5A5, 16'h7FFF, 32'h80000000});
				end
				3: begin
					write_reg(REG_AXIS_XY, rand64());
					write_reg(REG_AXIS_ZO, rand64());
				end
				default: begin
					write_reg(REG_AXIS_XY, {unit_comp(), unit_comp()});
					write_reg(REG_AXIS_ZO, {16'($urandom), 16'($urandom), unit_comp()});
				end
			endcase
			no_idle = (ph % 3 == 1);
			for (int n = 0; n < 115; n++)
				push_row(16'($urandom), rand_entry(), rand_entry(), rand_entry(), rand_entry());
			// The sender holds off until every pose row of the phase has arrived.
			drain();
		end

		if (mismatches == 0 && orphans == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
